// ===== hdl/cdsf_pkg.sv =====
// Package: word types, control structs and stencil tables for the stencil filter.
package cdsf_pkg;

  localparam int COEF_FRAC_BITS = 24;
  localparam int COEF_W         = COEF_FRAC_BITS + 8;
  localparam int DEF_MAX_TAPS   = 9;
  localparam int DEF_SAMPLE_W   = 32;
  localparam int FAMILIES       = 5;
  localparam int ORDERS         = 9;
  localparam int TAB_TAPS       = 9;
  localparam int TAP_W          = 4;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCURACY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

  localparam logic [2:0]  ACCURACY_RST = 3'd1;
  localparam logic [3:0]  ORDER_RST    = 4'd1;
  localparam logic [31:0] SCALE_RST    = 32'd65536;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               line_start;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] derivative;
    logic               unsupported;
    logic               saturated;
  } out_word_t;

  typedef struct packed {
    logic             accept;
    logic             acc_clr;
    logic             mul_en;
    logic             acc_add;
    logic             mag_en;
    logic             mlo_en;
    logic             mhi_en;
    logic             sum_en;
    logic             load_out;
    logic [TAP_W-1:0] tap;
  } cdsf_cmd_t;

  typedef struct packed {
    logic unsup;
    logic enough;
    logic last_tap;
    logic out_free;
  } cdsf_stat_t;

  localparam longint ONE = longint'(1) << COEF_FRAC_BITS;

  // coefficient m/d in Q.F, rounded to nearest, ties away from zero
  localparam longint COEF_TAB [FAMILIES][ORDERS][TAB_TAPS] = '{
    '{
      '{ONE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ONE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ONE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ONE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ONE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ONE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ONE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}
    },
    '{
      '{ONE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-((ONE+1)/2), 0, (ONE+1)/2, 0, 0, 0, 0, 0, 0},
      '{ONE, -2*ONE, ONE, 0, 0, 0, 0, 0, 0},
      '{-((ONE+1)/2), (2*ONE+1)/2, 0, -((2*ONE+1)/2), (ONE+1)/2, 0, 0, 0, 0},
      '{ONE, -4*ONE, 6*ONE, -4*ONE, ONE, 0, 0, 0, 0},
      '{-((ONE+1)/2), (4*ONE+1)/2, -((5*ONE+1)/2), 0, (5*ONE+1)/2,
        -((4*ONE+1)/2), (ONE+1)/2, 0, 0},
      '{ONE, -6*ONE, 15*ONE, -20*ONE, 15*ONE, -6*ONE, ONE, 0, 0},
      '{-((ONE+1)/2), (6*ONE+1)/2, -((14*ONE+1)/2), (14*ONE+1)/2, 0,
        -((14*ONE+1)/2), (14*ONE+1)/2, -((6*ONE+1)/2), (ONE+1)/2},
      '{ONE, -8*ONE, 28*ONE, -56*ONE, 70*ONE, -56*ONE, 28*ONE, -8*ONE, ONE}
    },
    '{
      '{ONE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{(ONE+6)/12, -((8*ONE+6)/12), 0, (8*ONE+6)/12, -((ONE+6)/12), 0, 0, 0, 0},
      '{-((ONE+6)/12), (16*ONE+6)/12, -((30*ONE+6)/12), (16*ONE+6)/12,
        -((ONE+6)/12), 0, 0, 0, 0},
      '{(ONE+4)/8, -((8*ONE+4)/8), (13*ONE+4)/8, 0, -((13*ONE+4)/8),
        (8*ONE+4)/8, -((ONE+4)/8), 0, 0},
      '{-((ONE+3)/6), (12*ONE+3)/6, -((39*ONE+3)/6), (56*ONE+3)/6,
        -((39*ONE+3)/6), (12*ONE+3)/6, -((ONE+3)/6), 0, 0},
      '{(ONE+3)/6, -((9*ONE+3)/6), (26*ONE+3)/6, -((29*ONE+3)/6), 0,
        (29*ONE+3)/6, -((26*ONE+3)/6), (9*ONE+3)/6, -((ONE+3)/6)},
      '{-((ONE+2)/4), (12*ONE+2)/4, -((52*ONE+2)/4), (116*ONE+2)/4,
        -((150*ONE+2)/4), (116*ONE+2)/4, -((52*ONE+2)/4), (12*ONE+2)/4,
        -((ONE+2)/4)},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}
    },
    '{
      '{ONE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-((ONE+30)/60), (9*ONE+30)/60, -((45*ONE+30)/60), 0, (45*ONE+30)/60,
        -((9*ONE+30)/60), (ONE+30)/60, 0, 0},
      '{(2*ONE+90)/180, -((27*ONE+90)/180), (270*ONE+90)/180,
        -((490*ONE+90)/180), (270*ONE+90)/180, -((27*ONE+90)/180),
        (2*ONE+90)/180, 0, 0},
      '{-((7*ONE+120)/240), (72*ONE+120)/240, -((338*ONE+120)/240),
        (488*ONE+120)/240, 0, -((488*ONE+120)/240), (338*ONE+120)/240,
        -((72*ONE+120)/240), (7*ONE+120)/240},
      '{(7*ONE+120)/240, -((96*ONE+120)/240), (676*ONE+120)/240,
        -((1952*ONE+120)/240), (2730*ONE+120)/240, -((1952*ONE+120)/240),
        (676*ONE+120)/240, -((96*ONE+120)/240), (7*ONE+120)/240},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}
    },
    '{
      '{ONE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{(3*ONE+420)/840, -((32*ONE+420)/840), (168*ONE+420)/840,
        -((672*ONE+420)/840), 0, (672*ONE+420)/840, -((168*ONE+420)/840),
        (32*ONE+420)/840, -((3*ONE+420)/840)},
      '{-((9*ONE+2520)/5040), (128*ONE+2520)/5040, -((1008*ONE+2520)/5040),
        (8064*ONE+2520)/5040, -((14350*ONE+2520)/5040), (8064*ONE+2520)/5040,
        -((1008*ONE+2520)/5040), (128*ONE+2520)/5040, -((9*ONE+2520)/5040)},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}
    }
  };

  localparam logic [2:0] RAD_TAB [FAMILIES][ORDERS] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4},
    '{3'd0, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd0, 3'd0},
    '{3'd0, 3'd3, 3'd3, 3'd4, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd4, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  localparam logic [ORDERS-1:0] STENCIL_OK [FAMILIES] = '{
    9'b001111111,
    9'b111111111,
    9'b001111111,
    9'b000011111,
    9'b000000111
  };

endpackage

// ===== hdl/cdsf_ctrl.sv =====
// Controller: sequences accept, tap accumulation, scaling and result hand-off.
module cdsf_ctrl
  import cdsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  cdsf_stat_t stat,
  output cdsf_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_DRAIN, S_ABS, S_MLO, S_MHI, S_SUM, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;

  always_comb begin
    state_nxt    = state_r;
    tap_nxt      = tap_r;
    cmd          = '0;
    cmd.tap      = tap_r;
    in_ready     = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept  = 1'b1;
          cmd.acc_clr = 1'b1;
          tap_nxt     = '0;
          if (stat.unsup) state_nxt = S_OUT;
          else if (stat.enough) state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_add = (tap_r != '0);
        if (stat.last_tap) state_nxt = S_DRAIN;
        else tap_nxt = tap_r + 1'b1;
      end
      S_DRAIN: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_ABS;
      end
      S_ABS: begin
        cmd.mag_en = 1'b1;
        state_nxt  = S_MLO;
      end
      S_MLO: begin
        cmd.mlo_en = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mhi_en = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

endmodule

// ===== hdl/cdsf_dp.sv =====
// Datapath: config registers, sample window, tap MAC, scale multiply, rounding, output reg.
module cdsf_dp
  import cdsf_pkg::*;
#(
  parameter int MAX_TAPS     = DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cdsf_cmd_t            cmd,
  output cdsf_stat_t           stat,
  input  in_word_t             in_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word
);

  localparam int IW = $clog2(MAX_TAPS);
  localparam int FW = $clog2(MAX_TAPS + 1);
  localparam int PW = COEF_W + SAMPLE_WIDTH;

  logic [2:0]  acc_half_r;
  logic [3:0]  order_r;
  logic [31:0] scale_r;

  logic signed [SAMPLE_WIDTH-1:0] win_r [MAX_TAPS];
  logic [FW-1:0]                  fill_r, fill_base, fill_nxt;

  logic                 sel_ok, unsup, unsup_r;
  logic [2:0]           rad;
  logic [TAP_W-1:0]     span, taps, widx;
  logic signed [COEF_W-1:0]       coef;
  logic signed [SAMPLE_WIDTH-1:0] wsel;
  logic signed [PW-1:0]           mul;

  logic [63:0] prod_r, acc_r, mag_r, plo_r, phi_r;
  logic        neg_r;
  logic [95:0] sum_r;
  logic [95:0] qv;
  logic [63:0] value;
  logic        over;
  out_word_t   res;
  out_word_t   out_word_r;
  logic        out_valid_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_half_r <= ACCURACY_RST;
      order_r    <= ORDER_RST;
      scale_r    <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCURACY: acc_half_r <= cfg_wdata[2:0];
        CFG_ORDER:    order_r    <= cfg_wdata[3:0];
        CFG_SCALE:    scale_r    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // stencil decode
  always_comb begin
    sel_ok = (acc_half_r < 3'(FAMILIES)) && (order_r < 4'(ORDERS));
    rad    = sel_ok ? RAD_TAB[acc_half_r][order_r] : 3'd0;
    span   = {rad, 1'b0};
    taps   = span + 1'b1;
    unsup  = !sel_ok || !STENCIL_OK[acc_half_r][order_r] ||
             ({1'b0, taps} > 5'(MAX_TAPS));
  end

  assign fill_base = in_word.line_start ? '0 : fill_r;
  assign fill_nxt  = (fill_base < FW'(MAX_TAPS)) ? fill_base + 1'b1 : fill_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      unsup_r <= 1'b0;
    end else if (cmd.accept) begin
      fill_r  <= fill_nxt;
      unsup_r <= unsup;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) win_r[i] <= '0;
    end else if (cmd.accept) begin
      for (int i = MAX_TAPS - 1; i > 0; i--) win_r[i] <= win_r[i-1];
      win_r[0] <= in_word.sample[SAMPLE_WIDTH-1:0];
    end
  end

  // tap i multiplies the sample 2r-i steps old
  assign widx = span - cmd.tap;
  assign wsel = win_r[widx[IW-1:0]];
  assign coef = COEF_W'(COEF_TAB[acc_half_r][order_r][cmd.tap]);
  assign mul  = coef * wsel;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= 64'(mul);
    if (cmd.acc_clr) acc_r <= '0;
    else if (cmd.acc_add) acc_r <= acc_r + prod_r;
    if (cmd.mag_en) begin
      neg_r <= acc_r[63];
      mag_r <= acc_r[63] ? (64'd0 - acc_r) : acc_r;
    end
    if (cmd.mlo_en) plo_r <= mag_r[31:0] * scale_r;
    if (cmd.mhi_en) phi_r <= mag_r[63:32] * scale_r;
    if (cmd.sum_en) sum_r <= {phi_r, 32'd0} + {32'd0, plo_r} +
                             (96'd1 << (COEF_FRAC_BITS - 1));
  end

  // round already added; drop fraction and saturate
  always_comb begin
    qv    = sum_r >> COEF_FRAC_BITS;
    value = qv[63:0];
    over  = |sum_r[95:COEF_FRAC_BITS+64];
    res   = '0;
    if (unsup_r) begin
      res.unsupported = 1'b1;
    end else if (!neg_r) begin
      if (over || value[63]) begin
        res.derivative = 64'h7FFF_FFFF_FFFF_FFFF;
        res.saturated  = 1'b1;
      end else begin
        res.derivative = value;
      end
    end else begin
      if (over || (value[63] && |value[62:0])) begin
        res.derivative = 64'h8000_0000_0000_0000;
        res.saturated  = 1'b1;
      end else begin
        res.derivative = 64'd0 - value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_word_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign stat.unsup    = unsup;
  assign stat.enough   = ({1'b0, taps} <= 5'(fill_nxt));
  assign stat.last_tap = (cmd.tap == span);
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

// ===== hdl/central_difference_stencil_filter.sv =====
// Top level: central finite-difference stencil filter.
//
//  channel  direction  handshake               word
//  in_      input      in_valid / in_ready     in_word_t  (sample, line_start)
//  out_     output     out_valid / out_ready   out_word_t (derivative, unsupported, saturated)
//  cfg_     input      cfg_we                  cfg_index, cfg_wdata
//
// A word that yields no result is taken in idle and leaves the controller there; an unsupported
// pair goes from idle straight to output. A computed result runs 2r+1 taps on the single tap
// multiplier, then drain, magnitude, the two-step 64x32 scale multiply, sum and output.
// Reset (rst_n low, synchronous) clears window, fill count and config to defaults.
// A result waiting in the output register does not block the next input word;
// a second result waits in the controller until the output register frees.
module central_difference_stencil_filter
  import cdsf_pkg::*;
#(
  parameter int MAX_TAPS     = DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  cdsf_cmd_t  cmd;
  cdsf_stat_t stat;

  cdsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdsf_dp #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// ===== sim/tb_central_difference_stencil_filter.sv =====
`timescale 1ns / 1ps
// Testbench: self-checking stream test of the central-difference stencil filter.
module tb_central_difference_stencil_filter
  import cdsf_pkg::*;
();

  localparam int N_FAM   = 5;
  localparam int N_ORD   = 9;
  localparam int WIN_LEN = 9;

  // stencil numerators, oldest tap first, over a common denominator
  localparam int NUMER [N_FAM][N_ORD][WIN_LEN] = '{
    '{
      '{1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}
    },
    '{
      '{1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-1, 0, 1, 0, 0, 0, 0, 0, 0},
      '{1, -2, 1, 0, 0, 0, 0, 0, 0},
      '{-1, 2, 0, -2, 1, 0, 0, 0, 0},
      '{1, -4, 6, -4, 1, 0, 0, 0, 0},
      '{-1, 4, -5, 0, 5, -4, 1, 0, 0},
      '{1, -6, 15, -20, 15, -6, 1, 0, 0},
      '{-1, 6, -14, 14, 0, -14, 14, -6, 1},
      '{1, -8, 28, -56, 70, -56, 28, -8, 1}
    },
    '{
      '{1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, -8, 0, 8, -1, 0, 0, 0, 0},
      '{-1, 16, -30, 16, -1, 0, 0, 0, 0},
      '{1, -8, 13, 0, -13, 8, -1, 0, 0},
      '{-1, 12, -39, 56, -39, 12, -1, 0, 0},
      '{1, -9, 26, -29, 0, 29, -26, 9, -1},
      '{-1, 12, -52, 116, -150, 116, -52, 12, -1},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}
    },
    '{
      '{1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-1, 9, -45, 0, 45, -9, 1, 0, 0},
      '{2, -27, 270, -490, 270, -27, 2, 0, 0},
      '{-7, 72, -338, 488, 0, -488, 338, -72, 7},
      '{7, -96, 676, -1952, 2730, -1952, 676, -96, 7},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}
    },
    '{
      '{1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{3, -32, 168, -672, 0, 672, -168, 32, -3},
      '{-9, 128, -1008, 8064, -14350, 8064, -1008, 128, -9},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}
    }
  };

  // zero denominator: no stencil for this pair
  localparam int DENOM [N_FAM][N_ORD] = '{
    '{1, 1, 1, 1, 1, 1, 1, 0, 0},
    '{1, 2, 1, 2, 1, 2, 1, 2, 1},
    '{1, 12, 12, 8, 6, 6, 4, 0, 0},
    '{1, 60, 180, 240, 240, 0, 0, 0, 0},
    '{1, 840, 5040, 0, 0, 0, 0, 0, 0}
  };

  localparam int RADIUS [N_FAM][N_ORD] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1, 1, 2, 2, 3, 3, 4, 4},
    '{0, 2, 2, 3, 3, 4, 4, 0, 0},
    '{0, 3, 3, 4, 4, 0, 0, 0, 0},
    '{0, 4, 4, 0, 0, 0, 0, 0, 0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  // predictor state
  longint      win [WIN_LEN];
  int          fill_cnt;
  logic [2:0]  acc_r;
  logic [3:0]  ord_r;
  logic [31:0] scale_r;

  out_word_t derivative_q [$];
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        stall_cycles = 0;

  central_difference_stencil_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // shifts one word into the window; returns 1 when a result is due
  function automatic bit compute_derivative(input in_word_t w, output out_word_t r);
    int          i, taps, rad, den, n;
    longint      m, c;
    logic [63:0] tap_sum, mag, value;
    logic [96:0] prod;
    logic [72:0] q;
    bit          neg, over;
    r = '0;
    if (w.line_start) fill_cnt = 0;
    for (i = WIN_LEN - 1; i > 0; i--) win[i] = win[i - 1];
    win[0] = longint'(w.sample);
    if (fill_cnt < WIN_LEN) fill_cnt++;
    den = 0;
    rad = 0;
    if (acc_r < N_FAM && ord_r < N_ORD) begin
      den = DENOM[acc_r][ord_r];
      rad = RADIUS[acc_r][ord_r];
    end
    taps = 2 * rad + 1;
    if (den == 0 || taps > WIN_LEN) begin
      r.unsupported = 1'b1;
      return 1'b1;
    end
    if (fill_cnt < taps) return 1'b0;
    tap_sum = '0;
    for (i = 0; i < taps; i++) begin
      n = NUMER[acc_r][ord_r][i];
      m = longint'(n < 0 ? -n : n) << COEF_FRAC_BITS;
      c = (2 * m + den) / (2 * den);
      if (n < 0) c = -c;
      tap_sum += c * win[taps - 1 - i];
    end
    neg = tap_sum[63];
    mag = neg ? -tap_sum : tap_sum;
    prod = 97'(mag) * 97'(scale_r) + (97'(1) << (COEF_FRAC_BITS - 1));
    q = 73'(prod >> COEF_FRAC_BITS);
    value = q[63:0];
    over = |q[72:64];
    if (!neg) begin
      if (over || value[63]) begin
        r.derivative = 64'h7FFF_FFFF_FFFF_FFFF;
        r.saturated = 1'b1;
      end else begin
        r.derivative = value;
      end
    end else begin
      if (over || value > 64'h8000_0000_0000_0000) begin
        r.derivative = 64'h8000_0000_0000_0000;
        r.saturated = 1'b1;
      end else begin
        r.derivative = -value;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_word_t predicted;
    if (rst_n) begin
      if (in_valid && in_ready && compute_derivative(in_word, predicted))
        derivative_q.push_back(predicted);
      if (out_valid && out_ready) begin
        if (derivative_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: derivative %0d unsupported %0b saturated %0b",
                     out_word.derivative, out_word.unsupported, out_word.saturated);
        end else begin
          predicted = derivative_q.pop_front();
          if (out_word.derivative !== predicted.derivative ||
              out_word.unsupported !== predicted.unsupported ||
              out_word.saturated !== predicted.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: derivative exp %0d got %0d, unsupported exp %0b got %0b, %s%0b got %0b",
                       predicted.derivative, out_word.derivative, predicted.unsupported,
                       out_word.unsupported, "saturated exp ", predicted.saturated,
                       out_word.saturated);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (stall_cycles) @(posedge clk);
        stall_cycles = 0;
      end
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #4000000;
    $display("tb_central_difference_stencil_filter failed");
    $finish;
  end

  task automatic send_word(input logic [31:0] smp, input bit first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{sample: smp, line_start: first};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (derivative_q.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic program_stencil(input logic [31:0] acc, input logic [31:0] ord,
                                 input logic [31:0] scale);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ACCURACY;
    cfg_wdata <= acc;
    @(posedge clk);
    cfg_index <= CFG_ORDER;
    cfg_wdata <= ord;
    @(posedge clk);
    cfg_index <= CFG_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_we <= 1'b0;
    acc_r = acc[2:0];
    ord_r = ord[3:0];
    scale_r = scale;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return 32'($signed($urandom_range(200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return 32'd65536;
      4: return $urandom;
      5: return $urandom_range(1, 1 << 20);
      default: return $urandom_range(32768, 262144);
    endcase
  endfunction

  task automatic test_directed();
    int k;
    // half-LSB results round away from zero
    program_stencil(32'd1, 32'd1, 32'd1);
    send_word(32'd0, 1'b1);
    send_word(32'd0, 1'b0);
    send_word(32'd1, 1'b0);
    send_word(32'd1, 1'b0);
    send_word(32'd0, 1'b0);
    wait_drained();
    // widest stencil, full scale, alternating extremes: clips both ways
    program_stencil(32'd4, 32'd2, 32'hFFFF_FFFF);
    for (k = 0; k < 10; k++) send_word(k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, k == 0);
    wait_drained();
    program_stencil(32'd0, 32'd0, 32'd65536);
    send_word(32'h7FFF_FFFF, 1'b1);
    send_word(32'h8000_0000, 1'b0);
    wait_drained();
    // pair missing from the table, then both registers at their top code
    program_stencil(32'd0, 32'd7, 32'd65536);
    send_word($urandom, 1'b0);
    wait_drained();
    program_stencil(32'd7, 32'd15, 32'hFFFF_FFFF);
    send_word($urandom, 1'b1);
    wait_drained();
  endtask

  task automatic test_stencil_sweep();
    int a, o, k;
    for (a = 0; a < N_FAM; a++) begin
      for (o = 0; o < N_ORD; o++) begin
        program_stencil(a, o, rand_scale());
        for (k = 0; k < 12; k++) send_word(rand_sample(), k == 0);
        wait_drained();
      end
    end
  endtask

  task automatic test_random_lines(input int n_items);
    int          sent, phase_len, line_left, k;
    logic [31:0] acc, ord;
    sent = 0;
    while (sent < n_items) begin
      acc = ($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(7);
      ord = ($urandom_range(9) < 8) ? $urandom_range(8) : $urandom_range(15);
      if ($urandom_range(3) == 0) begin
        acc = acc | ($urandom & ~32'h7);
        ord = ord | ($urandom & ~32'hF);
      end
      program_stencil(acc, ord, rand_scale());
      phase_len = $urandom_range(20, 60);
      line_left = 0;
      for (k = 0; k < phase_len; k++) begin
        if (line_left == 0) line_left = $urandom_range(1, 16);
        send_word(rand_sample(), line_left == 1 ? 1'b0 : ($urandom_range(15) == 0));
        line_left--;
      end
      sent += phase_len;
      wait_drained();
    end
  endtask

  task automatic test_pressure();
    int k, saved;
    saved = send_idle_pct;
    send_idle_pct = 0;
    program_stencil(32'd1, 32'd1, rand_scale());
    stall_cycles = 300;
    for (k = 0; k < 40; k++) send_word(rand_sample(), k == 0);
    // sender holds until the block has delivered everything
    in_valid <= 1'b0;
    @(posedge clk);
    while (derivative_q.size() != 0) @(posedge clk);
    for (k = 0; k < 20; k++) send_word(rand_sample(), 1'b0);
    send_idle_pct = saved;
    wait_drained();
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ACCURACY;
    cfg_wdata = '0;
    for (i = 0; i < WIN_LEN; i++) win[i] = 0;
    fill_cnt = 0;
    acc_r = ACCURACY_RST;
    ord_r = ORDER_RST;
    scale_r = SCALE_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 57;
    test_directed();
    test_stencil_sweep();

    send_idle_pct = 57;
    recv_idle_pct = 11;
    test_random_lines(260);
    test_pressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lines(220);

    wait_drained();
    if (mismatches == 0 && derivative_q.size() == 0)
      $display("tb_central_difference_stencil_filter passed");
    else
      $display("tb_central_difference_stencil_filter failed");
    $finish;
  end

endmodule
